// ===== hw/rtl/kfmm_pkg.sv =====
// shared constants, types and codes of the keyed fifo message matcher
`default_nettype none

package kfmm_pkg;

  localparam int ENTRIES     = 64;
  localparam int SOURCES     = 64;
  localparam int TAG_BITS    = 16;
  localparam int HANDLE_BITS = 32;

  localparam int SRC_BITS    = 6;
  localparam int TAG_IN_BITS = 16;
  localparam int HDL_IN_BITS = 32;
  localparam int ACT_BITS    = 7;
  localparam int PEND_BITS   = 7;
  localparam int STAMP_BITS  = 32;

  localparam int TG_BITS  = (TAG_BITS < TAG_IN_BITS) ? TAG_BITS : TAG_IN_BITS;
  localparam int HW_BITS  = (HANDLE_BITS < HDL_IN_BITS) ? HANDLE_BITS : HDL_IN_BITS;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  localparam logic [ACT_BITS-1:0] ACT_RESET = ACT_BITS'(64);

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_SRC   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RES
  } state_t;

  typedef struct packed {
    logic [STAMP_BITS-1:0] stamp;
    logic [HW_BITS-1:0]    handle;
    logic [TG_BITS-1:0]    tag;
    logic [SRC_BITS-1:0]   source;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_fifo_message_matcher.sv =====
// top level of the keyed fifo message matcher: store, scan sequencer and result register
//
// channel | direction | handshake             | contents
// in_     | slave     | in_tvalid/in_tready   | tuser kind, tdata source, tag, handle
// out_    | master    | out_tvalid/out_tready | tdata status, found_handle, pending_count
// cfg_    | write     | cfg_wr_en             | cfg_wr_data active_sources
//
// add and bad-source items skip the scan: the result state writes the result; idle takes the next item
// a find reads one entry per cycle through the shared compare unit
// a find compares all ENTRIES entries, then the result state writes the result; idle takes the next item
// reset is synchronous; valid bits clear at once, so there is no clearing pass
// a result waits in the output register; the next item is taken while it waits
// a stalled result holds the following item in the result state
`default_nettype none

module keyed_fifo_message_matcher (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [kfmm_pkg::IN_DATA_W-1:0]  in_tdata,   // source, tag, handle, zero pad
  input  wire logic                            in_tuser,   // kind
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [kfmm_pkg::OUT_DATA_W-1:0] out_tdata,  // status, found_handle, pending_count, zero pad
  input  wire logic                            cfg_wr_en,
  input  wire logic [kfmm_pkg::ACT_BITS-1:0]   cfg_wr_data
);

  import kfmm_pkg::*;

  state_t                 state_r, state_nxt;
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [STAMP_BITS-1:0]  stamp_r, stamp_nxt;
  logic [ACT_BITS-1:0]    active_r;

  logic                   kind_r, kind_nxt;
  logic [SRC_BITS-1:0]    src_r, src_nxt;
  logic [TG_BITS-1:0]     tag_r, tag_nxt;
  logic [HW_BITS-1:0]     hdl_r, hdl_nxt;
  logic                   bad_r, bad_nxt;

  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   iss_r, iss_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   cmp_last_r, cmp_last_nxt;
  logic                   hit_r, hit_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [STAMP_BITS-1:0]  best_age_r, best_age_nxt;
  logic [HW_BITS-1:0]     best_hdl_r, best_hdl_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic                   in_acc;
  logic                   in_bad;
  logic                   out_free;
  logic                   full;
  logic [IDX_W-1:0]       free_idx;
  logic [STAMP_BITS-1:0]  age;
  logic                   match;

  logic                   ram_we;
  entry_t                 ram_wdata;
  entry_t                 ram_rdata;

  kfmm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (free_idx),
    .wr_data (ram_wdata),
    .rd_en   (iss_r),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign full       = (cnt_r == CNT_W'(ENTRIES));

  assign in_bad = ({1'b0, in_tdata[SRC_BITS-1:0]} >= active_r)
               || (32'(in_tdata[SRC_BITS-1:0]) >= 32'(SOURCES));

  assign age   = stamp_r - ram_rdata.stamp;
  assign match = cmp_vld_r && valid_r[cmp_idx_r]
              && (ram_rdata.source == src_r) && (ram_rdata.tag == tag_r);

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == KIND_FIND && !in_bad) ? S_SCAN : S_RES;
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && cmp_last_r) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    status_t          res_st;
    logic [HW_BITS-1:0] res_hdl;
    logic [CNT_W-1:0] res_cnt;

    res_st  = ST_OK;
    res_hdl = '0;
    res_cnt = cnt_r;

    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    stamp_nxt      = stamp_r;
    kind_nxt       = kind_r;
    src_nxt        = src_r;
    tag_nxt        = tag_r;
    hdl_nxt        = hdl_r;
    bad_nxt        = bad_r;
    rd_idx_nxt     = rd_idx_r;
    iss_nxt        = 1'b0;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = rd_idx_r;
    cmp_last_nxt   = 1'b0;
    hit_nxt        = hit_r;
    best_idx_nxt   = best_idx_r;
    best_age_nxt   = best_age_r;
    best_hdl_nxt   = best_hdl_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_wdata.stamp  = stamp_r;
    ram_wdata.handle = hdl_r;
    ram_wdata.tag    = tag_r;
    ram_wdata.source = src_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt   = in_tuser;
          src_nxt    = in_tdata[SRC_BITS-1:0];
          tag_nxt    = in_tdata[SRC_BITS +: TG_BITS];
          hdl_nxt    = in_tdata[SRC_BITS + TAG_IN_BITS +: HW_BITS];
          bad_nxt    = in_bad;
          rd_idx_nxt = '0;
          iss_nxt    = (in_tuser == KIND_FIND) && !in_bad;
          hit_nxt    = 1'b0;
        end
      end
      S_SCAN: begin
        cmp_vld_nxt  = iss_r;
        cmp_last_nxt = iss_r && (rd_idx_r == IDX_W'(ENTRIES - 1));
        if (iss_r && !cmp_last_nxt) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          iss_nxt    = 1'b1;
        end
        if (match && (!hit_r || age > best_age_r)) begin
          hit_nxt      = 1'b1;
          best_idx_nxt = cmp_idx_r;
          best_age_nxt = age;
          best_hdl_nxt = ram_rdata.handle;
        end
      end
      S_RES: begin
        if (bad_r) begin
          res_st = ST_BAD_SRC;
        end else if (kind_r == KIND_ADD) begin
          if (full) begin
            res_st = ST_FULL;
          end else begin
            res_cnt = cnt_r + 1'b1;
          end
        end else if (!hit_r) begin
          res_st = ST_NOT_FOUND;
        end else begin
          res_hdl = best_hdl_r;
          res_cnt = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
        end
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_DATA_W - PEND_BITS - HDL_IN_BITS - 2)'(0),
                            PEND_BITS'(res_cnt), HDL_IN_BITS'(res_hdl), res_st};
          cnt_nxt        = res_cnt;
          if (!bad_r && kind_r == KIND_ADD && !full) begin
            ram_we             = 1'b1;
            valid_nxt[free_idx] = 1'b1;
            stamp_nxt          = stamp_r + 1'b1;
          end
          if (!bad_r && kind_r == KIND_FIND && hit_r) begin
            valid_nxt[best_idx_r] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      cnt_r        <= '0;
      stamp_r      <= '0;
      active_r     <= ACT_RESET;
      iss_r        <= 1'b0;
      cmp_vld_r    <= 1'b0;
      cmp_last_r   <= 1'b0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      stamp_r      <= stamp_nxt;
      iss_r        <= iss_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      cmp_last_r   <= cmp_last_nxt;
      hit_r        <= hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    src_r       <= src_nxt;
    tag_r       <= tag_nxt;
    hdl_r       <= hdl_nxt;
    bad_r       <= bad_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_age_r  <= best_age_nxt;
    best_hdl_r  <= best_hdl_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  a_cnt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("entry count differs from valid bits");

  a_find_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == KIND_FIND && !in_bad |=> state_r == S_SCAN && iss_r)
    else $error("find item did not start a scan");

  a_zero_hdl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tdata_r[1:0] != ST_OK |-> out_tdata_r[HDL_IN_BITS+1:2] == '0)
    else $error("failed item carries a handle");

endmodule

`default_nettype wire

// ===== hw/rtl/kfmm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module kfmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire
